[src/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared widths, constants and helper functions for the spot motion speed
// bargraph block.
// ----------------------------------------------------------------------------
package spm_pkg;

    // coordinate and bar sizes
    localparam int COORD_BITS = 10;
    localparam int BAR_LEDS   = 18;

    // distance and square root widths
    localparam int ROOT_W    = COORD_BITS + 1;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQ_CNT_W  = $clog2(ROOT_W + 1);
    localparam int DIST10_W  = ROOT_W + 4;

    // shared multiplier operand width
    localparam int MUL_W = DIST10_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // readout scaling: floor(d*10/31) by reciprocal multiply
    localparam longint SPEED_SCALE = 64'd10000000;
    localparam longint SPEED_DIV   = 64'd31;
    localparam longint BAR_BASE    = 64'd6000000;
    localparam longint BAR_STEP    = 64'd2500000;
    localparam int     READ_SHIFT  = DIST10_W + 5;
    localparam longint READ_MULT   = ((64'd1 << READ_SHIFT) + SPEED_DIV - 64'd1) / SPEED_DIV;

    // readout field
    localparam int READOUT_W   = 9;
    localparam int READ_RAW_W  = PROD_W - READ_SHIFT;
    localparam int READOUT_MAX = (1 << READOUT_W) - 1;

    // configuration port
    localparam int             PADDR_W      = 3;
    localparam int             PDATA_W      = 32;
    localparam int             DEADBAND_W   = 8;
    localparam logic           REG_DEADBAND = 1'b0;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd9;

    // position after reset
    localparam logic [COORD_BITS-1:0] LAST_X_RST = COORD_BITS'(619);
    localparam logic [COORD_BITS-1:0] LAST_Y_RST = COORD_BITS'(459);

    // smallest distance d that reaches bar threshold k:
    // floor(d*SCALE/31) >= T(k)  <=>  d >= ceil(31*T(k)/SCALE)
    function automatic longint bar_thr(input int k);
        longint t;
        t = BAR_BASE + BAR_STEP * longint'(k);
        return (SPEED_DIV * t + SPEED_SCALE - 64'd1) / SPEED_SCALE;
    endfunction

endpackage

[src/spm_apb.sv]
// ----------------------------------------------------------------------------
// spm_apb
// Configuration register file holding the movement deadband.
// ----------------------------------------------------------------------------
module spm_apb
    import spm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [DEADBAND_W-1:0] deadband
);

    logic [DEADBAND_W-1:0] deadband_reg;
    logic                  reg_sel;

    // word index of the access
    assign reg_sel = (paddr[PADDR_W-1] == REG_DEADBAND);

    // register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RST;
        end else if (psel && penable && pwrite && reg_sel) begin
            deadband_reg <= pwdata[DEADBAND_W-1:0];
        end
    end

    // read back
    assign prdata   = reg_sel ? PDATA_W'(deadband_reg) : '0;
    assign pready   = 1'b1;
    assign deadband = deadband_reg;

endmodule

[src/spm_mul.sv]
// ----------------------------------------------------------------------------
// spm_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module spm_mul
    import spm_pkg::*;
(
    input  logic              aclk,
    input  logic [MUL_W-1:0]  mul_a,
    input  logic [MUL_W-1:0]  mul_b,
    output logic [PROD_W-1:0] mul_p
);

    logic [PROD_W-1:0] prod_reg;

    // registered product
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_p = prod_reg;

endmodule

[src/spm_sqrt.sv]
// ----------------------------------------------------------------------------
// spm_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module spm_sqrt
    import spm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                run_reg;
    logic                done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                run_reg  <= 1'b1;
                cnt_reg  <= '0;
                done_reg <= 1'b0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(ROOT_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    // done only follows a running iteration
    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(run_reg))
        else $error("sqrt done without a running iteration");

    // no restart while iterating
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> !start)
        else $error("sqrt restarted while busy");

    // iteration count stays in range
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (cnt_reg < SQ_CNT_W'(ROOT_W)))
        else $error("sqrt step count out of range");

endmodule

[src/spot_motion_speed_bargraph.sv]
// ----------------------------------------------------------------------------
// spot_motion_speed_bargraph
// Light spot motion detector with distance, speed readout and LED bar.
// ----------------------------------------------------------------------------
// One request at a time. A sample inside the deadband on both axes goes from
// the axis differences straight to the output register. A moving sample
// passes these steps in order: the axis differences, two passes through the
// shared multiplier for dx*dx and dy*dy, the start of the root, the bit-serial
// square root unit (one distance bit per cycle), the wait for it to finish,
// one more multiplier pass for the readout scaling, the latch of readout and
// bar, then the output register. A new request is taken once the previous
// result sits in the output register, even if it is not yet taken; a result
// still waiting there adds its stall cycles. The readout and the bar hold their
// values until the next movement; the bar reads zero before the first movement.
module spot_motion_speed_bargraph
    import spm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // sample requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_x_sample,
    input  logic [COORD_BITS-1:0] s_y_sample,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_moved,
    output logic [READOUT_W-1:0]  m_speed_readout,
    output logic [BAR_LEDS-1:0]   m_led_bar,
    output logic [COORD_BITS-1:0] m_x_echo,
    output logic [COORD_BITS-1:0] m_y_echo
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MULX,
        ST_MULY,
        ST_ADD,
        ST_ROOT,
        ST_SCALE,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [DEADBAND_W-1:0] deadband;

    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [COORD_BITS-1:0] last_x_reg, last_y_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic                  moved_reg;
    logic [RAD_W-1:0]      sum_reg;
    logic [READOUT_W-1:0]  held_readout_reg;
    logic [BAR_LEDS-1:0]   held_bar_reg;
    logic [BAR_LEDS-1:0]   bar_next_reg;

    logic                  m_valid_reg;
    logic                  m_moved_reg;
    logic [READOUT_W-1:0]  m_readout_reg;
    logic [BAR_LEDS-1:0]   m_bar_reg;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;

    logic [COORD_BITS-1:0] dx_next, dy_next;
    logic                  moved_next;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [MUL_W-1:0]      dist10;
    logic [READ_RAW_W-1:0] read_raw;
    logic [READOUT_W-1:0]  readout_next;
    logic [BAR_LEDS-1:0]   bar_next;
    logic                  sq_start;
    logic                  sq_done;
    logic [ROOT_W-1:0]     sq_root;
    logic                  out_free;

    // configuration registers
    spm_apb u_apb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .deadband (deadband)
    );

    // shared multiplier
    spm_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // distance square root
    spm_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sum_reg + RAD_W'(mul_p)),
        .done     (sq_done),
        .root     (sq_root)
    );

    // per-axis distance and deadband test
    assign dx_next    = (x_reg >= last_x_reg) ? x_reg - last_x_reg : last_x_reg - x_reg;
    assign dy_next    = (y_reg >= last_y_reg) ? y_reg - last_y_reg : last_y_reg - y_reg;
    assign moved_next = (dx_next >= COORD_BITS'(deadband)) ||
                        (dy_next >= COORD_BITS'(deadband));

    // multiplier operand select
    assign dist10 = (MUL_W'(sq_root) << 3) + (MUL_W'(sq_root) << 1);
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MULX: begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            ST_MULY: begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            ST_SCALE: begin
                mul_a = dist10;
                mul_b = MUL_W'(READ_MULT);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // thermometer bar from the distance
    always_comb begin
        bar_next    = '0;
        bar_next[0] = 1'b1;
        for (int k = 0; k < BAR_LEDS - 1; k++) begin
            bar_next[k+1] = (64'(sq_root) >= bar_thr(k));
        end
    end

    // readout from the scaled product, saturated
    assign read_raw     = mul_p[PROD_W-1:READ_SHIFT];
    assign readout_next = (read_raw > READ_RAW_W'(READOUT_MAX)) ?
                          READOUT_W'(READOUT_MAX) : READOUT_W'(read_raw);

    assign sq_start = (state_reg == ST_ADD);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // sequencer and held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            last_x_reg       <= LAST_X_RST;
            last_y_reg       <= LAST_Y_RST;
            held_readout_reg <= '0;
            held_bar_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    state_reg <= moved_next ? ST_MULX : ST_OUT;
                end
                ST_MULX: begin
                    state_reg <= ST_MULY;
                end
                ST_MULY: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (sq_done) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    held_readout_reg <= readout_next;
                    held_bar_reg     <= bar_next_reg;
                    last_x_reg       <= x_reg;
                    last_y_reg       <= y_reg;
                    state_reg        <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_x_sample;
            y_reg <= s_y_sample;
        end
        if (state_reg == ST_DIFF) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            moved_reg <= moved_next;
        end
        if (state_reg == ST_MULY) begin
            sum_reg <= RAD_W'(mul_p);
        end
        if (state_reg == ST_SCALE) begin
            bar_next_reg <= bar_next;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_moved_reg   <= moved_reg;
            m_readout_reg <= held_readout_reg;
            m_bar_reg     <= held_bar_reg;
            m_x_reg       <= x_reg;
            m_y_reg       <= y_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_moved         = m_moved_reg;
    assign m_speed_readout = m_readout_reg;
    assign m_led_bar       = m_bar_reg;
    assign m_x_echo        = m_x_reg;
    assign m_y_echo        = m_y_reg;

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block still ready after a request was accepted");

    // a moving result always lights at least one led
    a_moved_lights_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_moved_reg) |-> m_bar_reg[0])
        else $error("movement result with an empty bar");

    // the bar is a thermometer code
    a_bar_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (((m_bar_reg + BAR_LEDS'(1)) & m_bar_reg) == '0))
        else $error("led bar is not a thermometer code");

    // the root finishes only while the sequencer waits for it
    a_root_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside its wait state");

endmodule
